[hdl/windowed_sorted_alarm_queue_assert.svh]
// assertion macros for the windowed sorted alarm queue
`ifndef WINDOWED_SORTED_ALARM_QUEUE_ASSERT_SVH
`define WINDOWED_SORTED_ALARM_QUEUE_ASSERT_SVH

// same-cycle implication
`define WSAQ_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("alarm queue check failed");

// next-cycle implication
`define WSAQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("alarm queue check failed");

`endif

[hdl/wsaq_pkg.sv]
// shared types and constants of the windowed sorted alarm queue
`default_nettype none

package wsaq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned LB_W = 12;
  localparam int unsigned CALC_W = 34;
  localparam int unsigned MAX_POP = 16;
  localparam int unsigned POP_W = 5;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned LOOK_AHEAD_DEF = 43200;
  localparam int unsigned DAY_SECONDS_DEF = 86400;
  localparam logic [LB_W-1:0] LB_RESET = 12'd3600;

  // word index of the look-back register
  localparam logic REG_LOOKBACK = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DUE    = 2'd0,
    KIND_RELOAD = 2'd1,
    KIND_FULL   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [WORD_W-1:0] stamp;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic signed [CALC_W-1:0] a;
    logic signed [CALC_W-1:0] b;
    logic                     sub;
  } alu_req_t;

endpackage

`default_nettype wire

[hdl/wsaq_alu.sv]
// shared signed add/subtract unit used for every time calculation and compare
`default_nettype none

module wsaq_alu
  import wsaq_pkg::*;
(
  input  alu_req_t                 req,
  output logic signed [CALC_W-1:0] res
);

  assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

`default_nettype wire

[hdl/wsaq_mem.sv]
// queue entry memory, one write port and one registered read port
`default_nettype none

module wsaq_mem
  import wsaq_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/wsaq_seq.sv]
// sequencer: queue bookkeeping, insert scan, tick pops and result register
`default_nettype none

module wsaq_seq
  import wsaq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned LOOK_AHEAD_SECONDS = LOOK_AHEAD_DEF,
  parameter int unsigned DAY_SECONDS = DAY_SECONDS_DEF,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               command,
  input  logic [WORD_W-1:0]        now_time,
  input  logic                     use_lookback,
  input  logic [WORD_W-1:0]        entry_time,
  input  logic                     entry_daily,
  input  logic [TAG_W-1:0]         entry_id,
  input  logic [LB_W-1:0]          lookback_seconds,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               kind,
  output logic [TAG_W-1:0]         alarm_id,
  output logic [WORD_W-1:0]        alarm_time,
  output logic                     last,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output entry_t                   mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  entry_t                   mem_rdata,
  output alu_req_t                 alu_req,
  input  logic signed [CALC_W-1:0] alu_res
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic signed [CALC_W-1:0] AHEAD_C = CALC_W'(LOOK_AHEAD_SECONDS);
  localparam logic signed [CALC_W-1:0] DAY_C = CALC_W'(DAY_SECONDS);
  localparam logic signed [CALC_W-1:0] HALF_C = CALC_W'(DAY_SECONDS / 2);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_CHK_HI = 11'b00000000010,
    ST_CHK_LO = 11'b00000000100,
    ST_SHIFT  = 11'b00000001000,
    ST_AHEAD  = 11'b00000010000,
    ST_BEHIND = 11'b00000100000,
    ST_PLACE  = 11'b00001000000,
    ST_SCAN   = 11'b00010000000,
    ST_PUT    = 11'b00100000000,
    ST_POP    = 11'b01000000000,
    ST_EMIT   = 11'b10000000000
  } state_t;

  // ring position of a logical queue slot
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  state_t              state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic                has_sent, has_sent_next;
  logic [WORD_W-1:0]   load_time, load_time_next;
  logic [LB_W-1:0]     active_lb, active_lb_next;
  logic [POP_W-1:0]    pops, pops_next;
  logic                out_valid_reg_q;
  logic                out_valid_next;

  logic signed [CALC_W-1:0] acc, acc_next;
  logic                flag_hi, flag_hi_next;
  logic                flag_lo, flag_lo_next;
  logic                win_ok, win_ok_next;
  logic [WORD_W-1:0]   t_reg, t_reg_next;
  logic [WORD_W-1:0]   now_reg, now_reg_next;
  logic                daily_reg, daily_reg_next;
  logic [TAG_W-1:0]    id_reg, id_reg_next;
  logic [AW-1:0]       scan_idx, scan_idx_next;
  kind_e               pend_kind, pend_kind_next;
  logic [TAG_W-1:0]    pend_id, pend_id_next;
  logic [WORD_W-1:0]   pend_time, pend_time_next;
  kind_e               out_kind, out_kind_next;
  logic [TAG_W-1:0]    out_id, out_id_next;
  logic [WORD_W-1:0]   out_time, out_time_next;
  logic                out_last, out_last_next;

  logic                out_free;
  logic                alu_neg;
  logic                sent_head;
  logic                due;
  logic                qual;
  logic                fits;
  logic                move;
  logic [AW-1:0]       tail_idx;
  logic [WORD_W-1:0]   sent_time;

  assign in_stall   = (state != ST_IDLE);
  assign out_valid  = out_valid_reg_q;
  assign kind       = out_kind;
  assign alarm_id   = out_id;
  assign alarm_time = out_time;
  assign last       = out_last;

  assign out_free  = !out_valid_reg_q || !out_stall;
  assign alu_neg   = alu_res[CALC_W-1];
  assign sent_head = has_sent && (count == CW'(1));
  assign tail_idx  = count[AW-1:0] - AW'(1);

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    has_sent_next  = has_sent;
    load_time_next = load_time;
    active_lb_next = active_lb;
    pops_next      = pops;
    acc_next       = acc;
    flag_hi_next   = flag_hi;
    flag_lo_next   = flag_lo;
    win_ok_next    = win_ok;
    t_reg_next     = t_reg;
    now_reg_next   = now_reg;
    daily_reg_next = daily_reg;
    id_reg_next    = id_reg;
    scan_idx_next  = scan_idx;
    pend_kind_next = pend_kind;
    pend_id_next   = pend_id;
    pend_time_next = pend_time;
    out_valid_next = out_valid_reg_q && out_stall;
    out_kind_next  = out_kind;
    out_id_next    = out_id;
    out_time_next  = out_time;
    out_last_next  = out_last;

    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = slot(head, '0);
    mem_wdata = '{stamp: t_reg, tag: id_reg};
    mem_raddr = slot(head, '0);

    due       = 1'b0;
    qual      = 1'b0;
    fits      = 1'b0;
    move      = 1'b0;
    sent_time = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_LOAD: begin
              alu_req.a   = {2'b00, now_time};
              alu_req.b   = AHEAD_C;
              alu_req.sub = 1'b0;
              sent_time   = alu_res[WORD_W] ? '1 : alu_res[WORD_W-1:0];
              mem_we         = 1'b1;
              mem_wdata      = '{stamp: sent_time, tag: '0};
              count_next     = CW'(1);
              has_sent_next  = 1'b1;
              load_time_next = now_time;
              active_lb_next = use_lookback ? lookback_seconds : '0;
            end
            CMD_INSERT: begin
              alu_req.a      = {2'b00, entry_time};
              alu_req.b      = {2'b00, load_time};
              alu_req.sub    = 1'b1;
              acc_next       = alu_res;
              daily_reg_next = entry_daily;
              id_reg_next    = entry_id;
              state_next     = ST_CHK_HI;
            end
            CMD_TICK: begin
              if (count != '0) begin
                now_reg_next = now_time;
                pops_next    = '0;
                state_next   = ST_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_CHK_HI: begin
        alu_req.a    = HALF_C;
        alu_req.b    = acc;
        alu_req.sub  = 1'b1;
        flag_hi_next = alu_neg;
        state_next   = ST_CHK_LO;
      end

      ST_CHK_LO: begin
        alu_req.a    = acc;
        alu_req.b    = HALF_C;
        alu_req.sub  = 1'b0;
        flag_lo_next = alu_neg;
        state_next   = ST_SHIFT;
      end

      ST_SHIFT: begin
        alu_req.a   = acc;
        alu_req.b   = (daily_reg && (flag_hi || flag_lo)) ? DAY_C : '0;
        alu_req.sub = flag_hi;
        acc_next    = alu_res;
        state_next  = ST_AHEAD;
      end

      ST_AHEAD: begin
        alu_req.a   = acc;
        alu_req.b   = AHEAD_C;
        alu_req.sub = 1'b1;
        win_ok_next = alu_neg;
        state_next  = ST_BEHIND;
      end

      ST_BEHIND: begin
        alu_req.a   = acc;
        alu_req.b   = {{(CALC_W - LB_W){1'b0}}, active_lb};
        alu_req.sub = 1'b0;
        win_ok_next = win_ok && !alu_neg;
        state_next  = ST_PLACE;
      end

      ST_PLACE: begin
        alu_req.a   = {2'b00, load_time};
        alu_req.b   = acc;
        alu_req.sub = 1'b0;
        fits        = (alu_res[CALC_W-1:WORD_W] == '0);
        t_reg_next  = alu_res[WORD_W-1:0];
        if (!(win_ok && fits)) begin
          state_next = ST_IDLE;
        end else if (count >= DEPTH_C) begin
          pend_kind_next = KIND_FULL;
          pend_id_next   = id_reg;
          pend_time_next = alu_res[WORD_W-1:0];
          state_next     = ST_EMIT;
        end else if (count == '0) begin
          mem_we     = 1'b1;
          mem_wdata  = '{stamp: alu_res[WORD_W-1:0], tag: id_reg};
          count_next = count + CW'(1);
          state_next = ST_IDLE;
        end else begin
          scan_idx_next = tail_idx;
          mem_raddr     = slot(head, tail_idx);
          state_next    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        alu_req.a   = {2'b00, mem_rdata.stamp};
        alu_req.b   = {2'b00, t_reg};
        alu_req.sub = 1'b1;
        move        = (has_sent && (scan_idx == tail_idx)) || !alu_neg;
        mem_we      = 1'b1;
        mem_waddr   = slot(head, scan_idx + AW'(1));
        if (move) begin
          mem_wdata = mem_rdata;
          if (scan_idx == '0) begin
            state_next = ST_PUT;
          end else begin
            scan_idx_next = scan_idx - AW'(1);
            mem_raddr     = slot(head, scan_idx - AW'(1));
          end
        end else begin
          count_next = count + CW'(1);
          state_next = ST_IDLE;
        end
      end

      ST_PUT: begin
        mem_we     = 1'b1;
        count_next = count + CW'(1);
        state_next = ST_IDLE;
      end

      ST_POP: begin
        alu_req.a   = {2'b00, now_reg};
        alu_req.b   = {2'b00, mem_rdata.stamp};
        alu_req.sub = 1'b1;
        due         = !alu_neg;
        qual        = (pops < POP_W'(MAX_POP)) && (count != '0) && !sent_head && due;
        if (pops == '0) begin
          if (!due) begin
            state_next = ST_IDLE;
          end else if (sent_head) begin
            pend_kind_next = KIND_RELOAD;
            pend_id_next   = '0;
            pend_time_next = mem_rdata.stamp;
            count_next     = '0;
            has_sent_next  = 1'b0;
            state_next     = ST_EMIT;
          end else begin
            pend_kind_next = KIND_DUE;
            pend_id_next   = mem_rdata.tag;
            pend_time_next = mem_rdata.stamp;
            head_next      = slot(head, AW'(1));
            count_next     = count - CW'(1);
            pops_next      = POP_W'(1);
          end
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = pend_kind;
          out_id_next    = pend_id;
          out_time_next  = pend_time;
          out_last_next  = !qual;
          if (qual) begin
            pend_kind_next = KIND_DUE;
            pend_id_next   = mem_rdata.tag;
            pend_time_next = mem_rdata.stamp;
            head_next      = slot(head, AW'(1));
            count_next     = count - CW'(1);
            pops_next      = pops + POP_W'(1);
          end else begin
            state_next = ST_IDLE;
          end
        end
        // keep the read aimed at the head after this cycle's pop
        mem_raddr = slot(head_next, '0);
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = pend_kind;
          out_id_next    = pend_id;
          out_time_next  = pend_time;
          out_last_next  = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      head            <= '0;
      count           <= '0;
      has_sent        <= 1'b0;
      load_time       <= '0;
      active_lb       <= '0;
      pops            <= '0;
      out_valid_reg_q <= 1'b0;
    end else begin
      state           <= state_next;
      head            <= head_next;
      count           <= count_next;
      has_sent        <= has_sent_next;
      load_time       <= load_time_next;
      active_lb       <= active_lb_next;
      pops            <= pops_next;
      out_valid_reg_q <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    acc       <= acc_next;
    flag_hi   <= flag_hi_next;
    flag_lo   <= flag_lo_next;
    win_ok    <= win_ok_next;
    t_reg     <= t_reg_next;
    now_reg   <= now_reg_next;
    daily_reg <= daily_reg_next;
    id_reg    <= id_reg_next;
    scan_idx  <= scan_idx_next;
    pend_kind <= pend_kind_next;
    pend_id   <= pend_id_next;
    pend_time <= pend_time_next;
    out_kind  <= out_kind_next;
    out_id    <= out_id_next;
    out_time  <= out_time_next;
    out_last  <= out_last_next;
  end

endmodule

`default_nettype wire

[hdl/windowed_sorted_alarm_queue.sv]
// top level of the windowed sorted alarm queue: config register and unit wiring
//
// Keeps up to QUEUE_DEPTH alarms in time order in a ring memory, with an
// optional end-of-window sentinel as the last entry. All time arithmetic and
// compares go through one shared 34-bit adder, so the block takes one item at
// a time and holds in_stall high while busy. A load is done in the cycle it is
// accepted. An insert steps through the checks, shift, window tests and
// placement; one that is stored into a non-empty queue then moves each later
// stored entry up to open its slot and writes it. A refused insert on a full
// queue then posts its beat. A tick on an empty queue returns to idle at once;
// otherwise it pops one beat per due entry (at most 16 pops). Any beat takes
// longer while out_stall holds the result register. The move and pop loops
// are bounded by the memory's single read and single write port.
`default_nettype none

module windowed_sorted_alarm_queue
  import wsaq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned LOOK_AHEAD_SECONDS = LOOK_AHEAD_DEF,
  parameter int unsigned DAY_SECONDS = DAY_SECONDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [WORD_W-1:0] now_time,
  input  logic              use_lookback,
  input  logic [WORD_W-1:0] entry_time,
  input  logic              entry_daily,
  input  logic [TAG_W-1:0]  entry_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [TAG_W-1:0]  alarm_id,
  output logic [WORD_W-1:0] alarm_time,
  output logic              last
);

  `include "windowed_sorted_alarm_queue_assert.svh"

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic [LB_W-1:0]          lookback_seconds;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  entry_t                   mem_wdata;
  entry_t                   mem_rdata;
  alu_req_t                 alu_req;
  logic signed [CALC_W-1:0] alu_res;

  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_LOOKBACK) ?
                  {{(APB_DW - LB_W){1'b0}}, lookback_seconds} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookback_seconds <= LB_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[APB_AW-1] == REG_LOOKBACK)) begin
      lookback_seconds <= pwdata[LB_W-1:0];
    end
  end

  wsaq_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  wsaq_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wsaq_seq #(
    .QUEUE_DEPTH        (QUEUE_DEPTH),
    .LOOK_AHEAD_SECONDS (LOOK_AHEAD_SECONDS),
    .DAY_SECONDS        (DAY_SECONDS)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .now_time         (now_time),
    .use_lookback     (use_lookback),
    .entry_time       (entry_time),
    .entry_daily      (entry_daily),
    .entry_id         (entry_id),
    .lookback_seconds (lookback_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .alarm_id         (alarm_id),
    .alarm_time       (alarm_time),
    .last             (last),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .alu_req          (alu_req),
    .alu_res          (alu_res)
  );

  // reload and refusal beats are always the only beat of their item
  `WSAQ_ASSERT_NOW(a_reload_last, clk, rst, out_valid && (kind == KIND_RELOAD), last)
  `WSAQ_ASSERT_NOW(a_full_last, clk, rst, out_valid && (kind == KIND_FULL), last)
  `WSAQ_ASSERT_NOW(a_reload_tag, clk, rst, out_valid && (kind == KIND_RELOAD), alarm_id == '0)
  // a load completes in its accept cycle
  `WSAQ_ASSERT_NEXT(a_load_one, clk, rst, in_valid && !in_stall && (command == CMD_LOAD), !in_stall)

endmodule

`default_nettype wire
